// File: hdl/rcpa_pkg.sv
// ----------------------------------------------------------------------------
// rcpa_pkg - shared types and constants of the page allocator
// Commands, status codes, field widths and the structs between the control
// path and the free-page chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpa_pkg;

    localparam int MAX_PAGES      = 256;
    localparam int COUNT_BITS_DEF = 16;
    localparam int PAGE_W         = 8;
    localparam int NODE_W         = 7;
    localparam int CNT_OUT_W      = 16;
    localparam int STATUS_W       = 3;
    localparam int CMD_W          = 2;

    localparam logic [NODE_W-1:0] NODE_NONE = '1;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETAIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RETAIN_FREE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_RELEASE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED      = 3'd5;

    // one entry of the free list, as held by a cell
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] id;
        logic [NODE_W-1:0] node;
    } free_ent_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              take;
        logic              push;
        logic [PAGE_W-1:0] push_id;
        logic [NODE_W-1:0] push_node;
        logic              req_ok;
        logic [NODE_W-1:0] req_node;
    } chain_ctl_t;

    // status returned by the chain
    typedef struct packed {
        logic              empty;
        logic [PAGE_W-1:0] sel_id;
        logic [NODE_W-1:0] sel_node;
    } chain_st_t;

endpackage

`default_nettype wire

// File: hdl/rcpa_ram.sv
// ----------------------------------------------------------------------------
// rcpa_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/rcpa_cell.sv
// ----------------------------------------------------------------------------
// rcpa_cell - one slot of the free-page chain
// Holds one free page and its node; loads on push at the first empty slot,
// shifts from its right neighbour when a page at or ahead of it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_cell
    import rcpa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire chain_ctl_t ctl,
    input  wire logic       left_valid,
    input  wire free_ent_t  right,
    input  wire logic       shift_sel,
    output free_ent_t       q,
    output logic            match,
    output logic            tail
);

    logic              valid_reg;
    logic [PAGE_W-1:0] id_reg;
    logic [NODE_W-1:0] node_reg;
    logic              match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.push && !valid_reg && left_valid) begin
            valid_reg <= 1'b1;
        end else if (ctl.take && shift_sel) begin
            valid_reg <= right.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push && !valid_reg && left_valid) begin
            id_reg   <= ctl.push_id;
            node_reg <= ctl.push_node;
        end else if (ctl.take && shift_sel) begin
            id_reg   <= right.id;
            node_reg <= right.node;
        end
        // compare against the requested node
        match_reg <= valid_reg && ctl.req_ok && (node_reg == ctl.req_node);
    end

    assign q.valid = valid_reg;
    assign q.id    = id_reg;
    assign q.node  = node_reg;
    assign match   = match_reg;
    assign tail    = valid_reg && !right.valid;

endmodule

`default_nettype wire

// File: hdl/rcpa_chain.sv
// ----------------------------------------------------------------------------
// rcpa_chain - ordered free list as a row of cells
// Oldest page in slot 0. Finds the first node match or else the tail, and
// removes the chosen page by shifting the slots behind it one place left.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_chain
    import rcpa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire chain_ctl_t ctl,
    output chain_st_t       st
);

    localparam int N    = MAX_PAGES;
    localparam int LOGN = $clog2(N);

    free_ent_t      ent [N];
    logic [N-1:0]   match;
    logic [N-1:0]   tail;
    logic [N-1:0]   hit_reg;
    logic [N-1:0]   shift_vec;
    logic [N-1:0]   match_pfx;
    logic [N-1:0]   first;
    logic [N-1:0]   hit_next;

    // inclusive prefix OR towards higher slots, log-depth
    function automatic logic [N-1:0] pfx_or(input logic [N-1:0] x);
        logic [N-1:0] p;
        p = x;
        for (int l = 0; l < LOGN; l++) begin
            p = p | (p << (1 << l));
        end
        return p;
    endfunction

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic      lv;
        free_ent_t rn;
        if (i == 0) begin : g_first
            assign lv = 1'b1;
        end else begin : g_mid
            assign lv = ent[i-1].valid;
        end
        if (i == N-1) begin : g_last
            assign rn = '0;
        end else begin : g_inner
            assign rn = ent[i+1];
        end
        rcpa_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_valid (lv),
            .right      (rn),
            .shift_sel  (shift_vec[i]),
            .q          (ent[i]),
            .match      (match[i]),
            .tail       (tail[i])
        );
    end

    // pick first match, else the newest entry
    always_comb begin
        match_pfx = pfx_or(match);
        first     = match & ~(match_pfx << 1);
        hit_next  = match_pfx[N-1] ? first : tail;
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
    end

    assign shift_vec = pfx_or(hit_reg);

    always_comb begin
        st.sel_id   = '0;
        st.sel_node = '0;
        for (int i = 0; i < N; i++) begin
            st.sel_id   = st.sel_id   | (hit_reg[i] ? ent[i].id   : '0);
            st.sel_node = st.sel_node | (hit_reg[i] ? ent[i].node : '0);
        end
        st.empty = !ent[0].valid;
    end

endmodule

`default_nettype wire

// File: hdl/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator - reference-counted page allocator
// Sequence: a beat is taken in idle, executed (count/node RAM read), and its
//   result loaded from the output state; allocate from the free list adds
//   the two-step search over the free-page chain (select, take). One beat is
//   in flight at a time; the next is taken after the return to idle. A
//   result held back by m_ready holds the next one.
// Reset: clears the pool size, the free chain valid bits and the handshake;
//   RAM contents stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_allocator
    import rcpa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [CMD_W-1:0]           s_command,
    input  wire logic [PAGE_W-1:0]          s_page_id,
    input  wire logic signed [NODE_W-1:0]   s_requested_node,
    // result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic [PAGE_W-1:0]               m_result_page,
    output logic [CNT_OUT_W-1:0]            m_ref_count,
    output logic signed [NODE_W-1:0]        m_home_node
);

    localparam int CW = $clog2(MAX_PAGES + 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_TAKE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         pages_created_reg, pages_created_next;

    // latched beat
    logic [CMD_W-1:0]      cmd_reg;
    logic [PAGE_W-1:0]     pid_reg;
    logic                  req_ok_reg;
    logic [NODE_W-1:0]     req_node_reg;

    // pending result
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PAGE_W-1:0]     res_page_reg, res_page_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic [NODE_W-1:0]     res_node_reg, res_node_next;

    // output register
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [PAGE_W-1:0]     m_page_reg;
    logic [CNT_OUT_W-1:0]  m_count_reg;
    logic [NODE_W-1:0]     m_node_reg;
    logic [31:0]           res_count_wide;

    // RAM ports
    logic [PAGE_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] rd_count;
    logic [NODE_W-1:0]     rd_node;
    logic                  cnt_we, node_we;
    logic [PAGE_W-1:0]     cnt_waddr, node_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [NODE_W-1:0]     node_wdata;

    chain_ctl_t            chain_ctl;
    chain_st_t             chain_st;

    logic                  accept;
    logic                  out_free;
    logic                  pid_bad;
    logic                  cnt_zero, cnt_max;
    logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
    logic [NODE_W-1:0]     take_node;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // hold the read address on the latched page once the beat is in
    assign rd_addr = (state_reg == S_IDLE) ? s_page_id : pid_reg;

    rcpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PAGES)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (rd_count)
    );

    rcpa_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PAGES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (rd_addr),
        .rdata (rd_node)
    );

    rcpa_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (chain_ctl),
        .st      (chain_st)
    );

    assign pid_bad   = CW'(pid_reg) >= pages_created_reg;
    assign cnt_zero  = (rd_count == '0);
    assign cnt_max   = &rd_count;
    assign cnt_inc   = rd_count + COUNT_BITS'(1);
    assign cnt_dec   = rd_count - COUNT_BITS'(1);
    // a reused page keeps its node unless a node is requested
    assign take_node = req_ok_reg ? req_node_reg : chain_st.sel_node;

    always_comb begin
        state_next         = state_reg;
        pages_created_next = pages_created_reg;
        res_status_next    = res_status_reg;
        res_page_next      = res_page_reg;
        res_count_next     = res_count_reg;
        res_node_next      = res_node_reg;
        cnt_we             = 1'b0;
        cnt_waddr          = pid_reg;
        cnt_wdata          = cnt_inc;
        node_we            = 1'b0;
        node_waddr         = pid_reg;
        node_wdata         = req_node_reg;
        chain_ctl.take      = 1'b0;
        chain_ctl.push      = 1'b0;
        chain_ctl.push_id   = pid_reg;
        chain_ctl.push_node = rd_node;
        chain_ctl.req_ok    = req_ok_reg;
        chain_ctl.req_node  = req_node_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
                if (cmd_reg == CMD_ALLOC) begin
                    if (!chain_st.empty) begin
                        state_next = S_SEL;
                    end else if (pages_created_reg < CW'(MAX_PAGES)) begin
                        // fresh id
                        pages_created_next = pages_created_reg + CW'(1);
                        cnt_we          = 1'b1;
                        cnt_waddr       = pages_created_reg[PAGE_W-1:0];
                        cnt_wdata       = COUNT_BITS'(1);
                        node_we         = 1'b1;
                        node_waddr      = pages_created_reg[PAGE_W-1:0];
                        node_wdata      = req_node_reg;
                        res_status_next = ST_OK;
                        res_page_next   = pages_created_reg[PAGE_W-1:0];
                        res_count_next  = COUNT_BITS'(1);
                        res_node_next   = req_node_reg;
                    end else begin
                        res_status_next = ST_EXHAUSTED;
                        res_page_next   = '0;
                        res_count_next  = '0;
                        res_node_next   = NODE_NONE;
                    end
                end else if (pid_bad) begin
                    res_status_next = ST_INVALID;
                    res_page_next   = pid_reg;
                    res_count_next  = '0;
                    res_node_next   = NODE_NONE;
                end else begin
                    res_page_next   = pid_reg;
                    res_node_next   = rd_node;
                    res_status_next = ST_OK;
                    res_count_next  = rd_count;
                    unique case (cmd_reg)
                        CMD_RETAIN: begin
                            if (cnt_zero) begin
                                res_status_next = ST_RETAIN_FREE;
                            end else if (cnt_max) begin
                                res_status_next = ST_OVERFLOW;
                            end else begin
                                cnt_we         = 1'b1;
                                cnt_wdata      = cnt_inc;
                                res_count_next = cnt_inc;
                            end
                        end
                        CMD_RELEASE: begin
                            if (cnt_zero) begin
                                res_status_next = ST_DOUBLE_RELEASE;
                            end else begin
                                cnt_we         = 1'b1;
                                cnt_wdata      = cnt_dec;
                                res_count_next = cnt_dec;
                                // last reference gone: append to the free list
                                chain_ctl.push = (cnt_dec == '0);
                            end
                        end
                        CMD_QUERY: begin
                            res_status_next = ST_OK;
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SEL: begin
                state_next = S_TAKE;
            end
            S_TAKE: begin
                chain_ctl.take  = 1'b1;
                cnt_we          = 1'b1;
                cnt_waddr       = chain_st.sel_id;
                cnt_wdata       = COUNT_BITS'(1);
                node_we         = 1'b1;
                node_waddr      = chain_st.sel_id;
                node_wdata      = take_node;
                res_status_next = ST_OK;
                res_page_next   = chain_st.sel_id;
                res_count_next  = COUNT_BITS'(1);
                res_node_next   = take_node;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            pages_created_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            pages_created_reg <= pages_created_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign res_count_wide = 32'(res_count_reg);

    // payload: latch the beat, hold the pending result, load the output stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_command;
            pid_reg      <= s_page_id;
            req_ok_reg   <= !s_requested_node[NODE_W-1];
            req_node_reg <= s_requested_node[NODE_W-1] ? NODE_NONE
                                                       : s_requested_node;
        end
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_count_reg  <= res_count_next;
        res_node_reg   <= res_node_next;
        if (state_reg == S_OUT && out_free) begin
            m_status_reg <= res_status_reg;
            m_page_reg   <= res_page_reg;
            m_count_reg  <= res_count_wide[CNT_OUT_W-1:0];
            m_node_reg   <= res_node_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_result_page = m_page_reg;
    assign m_ref_count   = m_count_reg;
    assign m_home_node   = m_node_reg;

    // pool never grows past capacity
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_created_reg <= CW'(MAX_PAGES))
        else $error("pool size beyond capacity");

    // a page is only taken from a non-empty chain
    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAKE) |-> !chain_st.empty)
        else $error("take from empty free chain");

    // an accepted beat starts execution next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    // a result appears only from the output state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the reference-counted page allocator
// Sends allocate, retain, release and query beats into the block, takes
// each reply from the directed table or works it out from a software copy
// of the page pool, and compares the replies field by field in order. Both
// channels idle at random; the run covers a directed table, two random
// phases around a full pool, and a short back-to-back retain burst on one
// live page.
module tb_top;
    import rcpa_pkg::*;

    localparam int          CNT_BITS      = COUNT_BITS_DEF;
    localparam longint      CNT_MAX       = (64'd1 << CNT_BITS) - 1;
    localparam int          MAX_GAP       = 12;
    localparam int          RAND_EARLY    = 800;
    localparam int          RAND_LATE     = 400;
    localparam int          BURST_LEN     = 40;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          MAX_PRINTS    = 30;

    // one reply beat, in port order
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [PAGE_W-1:0]        page;
        logic [CNT_OUT_W-1:0]     count;
        logic signed [NODE_W-1:0] node;
    } page_reply_t;

    // one row of the directed table; typed rows carry their reply
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
        logic [NODE_W-1:0] node;
        logic              typed;
        page_reply_t       reply;
    } dir_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command;
    logic [PAGE_W-1:0]          s_page_id;
    logic signed [NODE_W-1:0]   s_requested_node;
    logic                       m_valid;
    logic                       m_ready;
    logic [STATUS_W-1:0]        m_status;
    logic [PAGE_W-1:0]          m_result_page;
    logic [CNT_OUT_W-1:0]       m_ref_count;
    logic signed [NODE_W-1:0]   m_home_node;

    // software copy of the page pool
    int unsigned                pool_size;
    int unsigned                page_refs [MAX_PAGES];
    logic signed [NODE_W-1:0]   page_home [MAX_PAGES];
    logic [PAGE_W-1:0]          free_pages [$];

    // replies owed by the block, oldest first
    page_reply_t                replies_due [$];

    logic                       idle_on;
    int unsigned                next_gap;
    int unsigned                errors;
    int unsigned                beats_sent;
    int unsigned                replies_seen;
    int unsigned                status_hits [8];

    refcounted_page_allocator #(
        .COUNT_BITS(CNT_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_page_id       (s_page_id),
        .s_requested_node(s_requested_node),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_page   (m_result_page),
        .m_ref_count     (m_ref_count),
        .m_home_node     (m_home_node)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: the slowest legal run is well under a tenth of this.
    initial begin : watchdog
        #(40_000_000);
        $display("refcounted_page_allocator: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pool predictor: apply one accepted beat to the copy, return its reply.
    // ------------------------------------------------------------------------
    function automatic page_reply_t pool_step(logic [CMD_W-1:0] cmd,
                                              logic [PAGE_W-1:0] pid,
                                              logic [NODE_W-1:0] raw);
        page_reply_t              rep;
        logic                     no_pref;
        logic signed [NODE_W-1:0] want;
        logic                     hit;
        int                       pos;
        int                       i;
        logic [PAGE_W-1:0]        id;
        int unsigned              c;

        // any negative request means no preference, held as the none code
        no_pref = raw[NODE_W-1];
        want    = no_pref ? NODE_NONE : raw;

        if (cmd == CMD_ALLOC) begin
            if (free_pages.size() > 0) begin
                // default to the newest free page, then look for a node match
                pos = free_pages.size() - 1;
                hit = 1'b0;
                if (!no_pref) begin
                    for (i = 0; i < free_pages.size(); i++) begin
                        if (!hit && page_home[free_pages[i]] == want) begin
                            pos = i;
                            hit = 1'b1;
                        end
                    end
                end
                id = free_pages[pos];
                free_pages.delete(pos);
                if (!no_pref) page_home[id] = want;
            end else if (pool_size >= MAX_PAGES) begin
                rep = {ST_EXHAUSTED, {PAGE_W{1'b0}}, {CNT_OUT_W{1'b0}}, NODE_NONE};
                return rep;
            end else begin
                // fresh page always takes the request, none included
                id = pool_size[PAGE_W-1:0];
                pool_size++;
                page_home[id] = want;
            end
            page_refs[id] = 1;
            rep = {ST_OK, id, {{(CNT_OUT_W-1){1'b0}}, 1'b1}, page_home[id]};
        end else if (pid >= pool_size) begin
            rep = {ST_INVALID, pid, {CNT_OUT_W{1'b0}}, NODE_NONE};
        end else begin
            c   = page_refs[pid];
            rep = {ST_OK, pid, c[CNT_OUT_W-1:0], page_home[pid]};
            case (cmd)
                CMD_RETAIN: begin
                    if (c == 0) begin
                        rep.status = ST_RETAIN_FREE;
                    end else if (c >= CNT_MAX) begin
                        rep.status = ST_OVERFLOW;
                    end else begin
                        c              = c + 1;
                        page_refs[pid] = c;
                        rep.count      = c[CNT_OUT_W-1:0];
                    end
                end
                CMD_RELEASE: begin
                    if (c == 0) begin
                        rep.status = ST_DOUBLE_RELEASE;
                    end else begin
                        c              = c - 1;
                        page_refs[pid] = c;
                        rep.count      = c[CNT_OUT_W-1:0];
                        if (c == 0 && free_pages.size() < MAX_PAGES)
                            free_pages.insert(free_pages.size(), pid);
                    end
                end
                default: begin
                end
            endcase
        end
        return rep;
    endfunction

    function automatic dir_row_t dir_row(logic [CMD_W-1:0] cmd, int page, int node,
                                         logic typed, logic [STATUS_W-1:0] st,
                                         int rpage, int cnt, int rnode);
        dir_row_t r;
        r.cmd   = cmd;
        r.page  = page[PAGE_W-1:0];
        r.node  = node[NODE_W-1:0];
        r.typed = typed;
        r.reply = {st, rpage[PAGE_W-1:0], cnt[CNT_OUT_W-1:0], rnode[NODE_W-1:0]};
        return r;
    endfunction

    // Lean on a handful of nodes so that node matches on the free list occur.
    function automatic logic [NODE_W-1:0] pick_node();
        case ($urandom_range(0, 7))
            0:       return NODE_W'($urandom_range(0, 127));
            1:       return NODE_NONE;
            2:       return 7'd63;
            default: return NODE_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (errors < MAX_PRINTS)
            $display("[%0t] error: %s got %0d want %0d", $realtime, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Input side. Hold valid and the payload until the beat is taken, then
    // draw the gap before the next one; lower valid only if that gap is not
    // zero, so a back-to-back beat never sees valid dropped and raised in the
    // same step.
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pid,
                             logic [NODE_W-1:0] node, logic typed,
                             page_reply_t typed_reply);
        page_reply_t rep;
        repeat (next_gap) @(posedge aclk);
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_page_id        <= pid;
        s_requested_node <= node;
        do @(posedge aclk); while (!s_ready);
        rep = pool_step(cmd, pid, node);
        replies_due.insert(replies_due.size(), typed ? typed_reply : rep);
        beats_sent++;
        status_hits[rep.status]++;
        next_gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (next_gap != 0) s_valid <= 1'b0;
    endtask

    task automatic random_beat(int unsigned alloc_pct);
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] pid;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            cmd = CMD_ALLOC;
        end else begin
            pick = $urandom_range(0, 9);
            cmd  = (pick < 4) ? CMD_RELEASE : (pick < 7) ? CMD_RETAIN : CMD_QUERY;
        end
        // mostly live pages; now and then any id, which may be past the pool
        if (pool_size == 0 || $urandom_range(0, 7) == 0)
            pid = PAGE_W'($urandom_range(0, 255));
        else
            pid = PAGE_W'($urandom_range(0, pool_size - 1));
        send_beat(cmd, pid, pick_node(), 1'b0, '0);
    endtask

    // Drop valid and hold off until every owed reply is back.
    task automatic wait_replies();
        if (next_gap == 0) s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due.size() != 0);
        next_gap = 0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall a random number of cycles per beat, then take it and
    // compare against the oldest owed reply.
    // ------------------------------------------------------------------------
    initial begin : reply_sink
        int unsigned stall;
        page_reply_t got;
        page_reply_t want;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_status, m_result_page, m_ref_count, m_home_node};
            replies_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch("reply with nothing owed, status", got.status, 0);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.page !== want.page)
                    report_mismatch("result_page", got.page, want.page);
                if (got.count !== want.count)
                    report_mismatch("ref_count", got.count, want.count);
                if (got.node !== want.node)
                    report_mismatch("home_node", got.node, want.node);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t rows [$];
        int       sat_page;
        int       i;
        int       k;

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_command        <= CMD_QUERY;
        s_page_id        <= '0;
        s_requested_node <= '0;
        idle_on          = 1'b1;
        next_gap         = 0;
        errors           = 0;
        beats_sent       = 0;
        replies_seen     = 0;
        pool_size        = 0;
        foreach (status_hits[k]) status_hits[k] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. Typed replies are the ones obvious from the rules:
        // out-of-pool ids, fresh pages straight after reset, release of a
        // freed page and retain of a freed page. Free-list picks go to the
        // predictor.
        rows = '{
            dir_row(CMD_QUERY,     0,   0, 1'b1, ST_INVALID,        0,   0, -1),
            dir_row(CMD_RETAIN,  255,   0, 1'b1, ST_INVALID,      255,   0, -1),
            dir_row(CMD_RELEASE, 128,   0, 1'b1, ST_INVALID,      128,   0, -1),
            dir_row(CMD_ALLOC,     0,  -1, 1'b1, ST_OK,             0,   1, -1),
            dir_row(CMD_ALLOC,   255,  63, 1'b1, ST_OK,             1,   1, 63),
            // most negative request: no preference, held as none
            dir_row(CMD_ALLOC,     0, -64, 1'b1, ST_OK,             2,   1, -1),
            dir_row(CMD_ALLOC,     0,   0, 1'b1, ST_OK,             3,   1,  0),
            dir_row(CMD_QUERY,     4,   0, 1'b1, ST_INVALID,        4,   0, -1),
            dir_row(CMD_RETAIN,    1,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_RELEASE,   1,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_RELEASE,   1,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_RELEASE,   1,   0, 1'b1, ST_DOUBLE_RELEASE, 1,   0, 63),
            dir_row(CMD_RETAIN,    1,   0, 1'b1, ST_RETAIN_FREE,    1,   0, 63),
            dir_row(CMD_QUERY,     1,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_RELEASE,   3,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_RELEASE,   0,   0, 1'b0, ST_OK,             0,   0,  0),
            // node match in the middle of the free list
            dir_row(CMD_ALLOC,     0,   0, 1'b0, ST_OK,             0,   0,  0),
            // no preference: newest free page, node kept
            dir_row(CMD_ALLOC,     0,  -1, 1'b0, ST_OK,             0,   0,  0),
            // no match: newest free page, node overwritten
            dir_row(CMD_ALLOC,     0,   5, 1'b0, ST_OK,             0,   0,  0),
            // free list empty: fresh id
            dir_row(CMD_ALLOC,     0,   7, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_QUERY,   255,   0, 1'b1, ST_INVALID,      255,   0, -1),
            dir_row(CMD_RELEASE,   2,   0, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_ALLOC,     0,  63, 1'b0, ST_OK,             0,   0,  0),
            dir_row(CMD_QUERY,     2,   0, 1'b0, ST_OK,             0,   0,  0)
        };
        foreach (rows[i])
            send_beat(rows[i].cmd, rows[i].page, rows[i].node, rows[i].typed,
                      rows[i].reply);
        wait_replies();

        // Early random phase: pool still growing, so out-of-pool ids occur.
        // Switch idling off for the odd stretch and drain now and then.
        for (i = 0; i < RAND_EARLY; i++) begin
            if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            random_beat(30);
            if (i % 250 == 249) wait_replies();
        end
        idle_on = 1'b1;
        wait_replies();

        // Fill the pool to capacity, then knock on the door a few times.
        while (!(free_pages.size() == 0 && pool_size == MAX_PAGES))
            send_beat(CMD_ALLOC, PAGE_W'($urandom_range(0, 255)), pick_node(),
                      1'b0, '0);
        repeat (3) send_beat(CMD_ALLOC, PAGE_W'($urandom_range(0, 255)), pick_node(),
                             1'b0, '0);

        // Late random phase: full pool, allocation-heavy, so the free list
        // keeps running dry and exhaustion recurs.
        for (i = 0; i < RAND_LATE; i++) begin
            if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            random_beat(60);
        end
        wait_replies();

        // Retain burst on one live page, no idling on either side.
        idle_on  = 1'b0;
        sat_page = -1;
        while (sat_page < 0) begin
            k = $urandom_range(0, MAX_PAGES - 1);
            for (i = 0; i < MAX_PAGES; i++) begin
                if (sat_page < 0 && page_refs[(k + i) % MAX_PAGES] != 0)
                    sat_page = (k + i) % MAX_PAGES;
            end
            if (sat_page < 0)
                send_beat(CMD_ALLOC, '0, NODE_NONE, 1'b0, '0);
        end
        repeat (BURST_LEN) send_beat(CMD_RETAIN, PAGE_W'(sat_page), pick_node(), 1'b0, '0);
        send_beat(CMD_QUERY, PAGE_W'(sat_page), pick_node(), 1'b0, '0);
        send_beat(CMD_RELEASE, PAGE_W'(sat_page), pick_node(), 1'b0, '0);
        send_beat(CMD_RETAIN, PAGE_W'(sat_page), pick_node(), 1'b0, '0);
        send_beat(CMD_RETAIN, PAGE_W'(sat_page), pick_node(), 1'b0, '0);

        // Drain, then watch a little longer for stray replies.
        wait_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d beats in, %0d replies out, pool at %0d pages",
                 beats_sent, replies_seen, pool_size);
        $display("run: %0d out-of-pool, %0d double releases, %0d free retains, %0d exhausted",
                 status_hits[ST_INVALID], status_hits[ST_DOUBLE_RELEASE],
                 status_hits[ST_RETAIN_FREE], status_hits[ST_EXHAUSTED]);
        if (errors == 0)
            $display("refcounted_page_allocator: match");
        else
            $display("refcounted_page_allocator: mismatch");
        $finish;
    end

endmodule
